// ===== rtl/core/rwcg_pkg.sv =====
// Shared types and constants for the raycaster wall column geometry core.
// No dependencies; imported by the front end, back end and core top.
`default_nettype none

package rwcg_pkg;

  localparam int POS_W    = 24;
  localparam int DIR_W    = 19;
  localparam int CELL_W   = 8;
  localparam int NUM_W    = 26;
  localparam int AN_W     = 25;
  localparam int AN_LO_W  = 8;
  localparam int AN_HI_W  = AN_W - AN_LO_W;
  localparam int AD_W     = 19;
  localparam int DIST_W   = 24;
  localparam int HGT_W    = 16;
  localparam int ROW_W    = 10;
  localparam int FRAC_W   = 16;

  localparam logic [DIST_W-1:0] DIST_MAX   = 24'hFF_FFFF;
  localparam logic [DIST_W-1:0] DIST_MIN   = 24'd7;
  localparam logic [HGT_W-1:0]  HEIGHT_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    KIND_DIVIDE,
    KIND_BEHIND,
    KIND_NO_DIR
  } item_kind_t;

  typedef struct packed {
    item_kind_t               kind;
    logic                     qovf;
    logic [AN_HI_W-1:0]       an_hi;
    logic [AN_LO_W-1:0]       an_lo;
    logic [AD_W-1:0]          ad;
    logic [FRAC_W-1:0]        opos;
    logic signed [DIR_W-1:0]  odir;
  } front_item_t;

  typedef struct packed {
    logic [DIST_W-1:0] wall_distance;
    logic [HGT_W-1:0]  slice_height;
    logic [ROW_W-1:0]  row_first;
    logic [ROW_W-1:0]  row_last;
    logic [FRAC_W-1:0] texture_frac;
    logic              saturated;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/rwcg_fifo.sv =====
// Small synchronous queue with push/full and pop/empty sides.
// Generic width and depth; no package dependencies.
`default_nettype none

module rwcg_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  output logic                  full,
  input  wire logic [WIDTH-1:0] din,
  output logic                  empty,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      dout
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             wr;
  logic             rd;

  assign full  = (count == DEPTH_CNT);
  assign empty = (count == '0);
  assign wr    = push && !full;
  assign rd    = pop && !empty;
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/rwcg_front.sv =====
// Front end: accepts a column item, picks the hit axis and classifies it.
// Depends on rwcg_pkg for the work item type and widths.
`default_nettype none

module rwcg_front (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     push,
  output logic                          full,
  input  wire logic [23:0]              viewer_x,
  input  wire logic [23:0]              viewer_y,
  input  wire logic signed [18:0]       dir_x,
  input  wire logic signed [18:0]       dir_y,
  input  wire logic [7:0]               cell_x,
  input  wire logic [7:0]               cell_y,
  input  wire logic                     hit_side,
  output logic                          item_valid,
  output rwcg_pkg::front_item_t         item,
  input  wire logic                     item_full
);

  import rwcg_pkg::*;

  logic                    accept;
  logic [CELL_W-1:0]       hit_cell;
  logic [POS_W-1:0]        pos;
  logic signed [DIR_W-1:0] dir;
  logic                    dneg;
  logic [NUM_W-1:0]        num;
  logic [NUM_W-1:0]        num_abs;
  logic [AN_W-1:0]         an;
  logic [AD_W-1:0]         ad;
  logic                    behind;
  front_item_t             item_next;

  assign full   = item_valid && item_full;
  assign accept = push && !full;

  always_comb begin
    hit_cell = hit_side ? cell_y : cell_x;
    pos      = hit_side ? viewer_y : viewer_x;
    dir      = hit_side ? dir_y : dir_x;
    dneg     = dir[DIR_W-1];
    // cell edge minus position, one cell further when stepping backward
    num     = {2'b00, hit_cell, 16'h0000} - {2'b00, pos} + {9'd0, dneg, 16'h0000};
    num_abs = num[NUM_W-1] ? (~num + 1'b1) : num;
    an      = num_abs[AN_W-1:0];
    ad      = dneg ? AD_W'(~dir + 1'b1) : AD_W'(dir);
    behind  = (num != '0) && (num[NUM_W-1] != dneg);

    if (dir == '0) begin
      item_next.kind = KIND_NO_DIR;
    end else if (behind) begin
      item_next.kind = KIND_BEHIND;
    end else begin
      item_next.kind = KIND_DIVIDE;
    end
    // quotient reaches 2^24 exactly when an >= ad * 2^8
    item_next.qovf  = ({2'b00, an} >= {ad, 8'h00});
    item_next.an_hi = an[AN_W-1:AN_LO_W];
    item_next.an_lo = an[AN_LO_W-1:0];
    item_next.ad    = ad;
    item_next.opos  = hit_side ? viewer_x[FRAC_W-1:0] : viewer_y[FRAC_W-1:0];
    item_next.odir  = hit_side ? dir_x : dir_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      item_valid <= accept || (item_valid && item_full);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= item_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/rwcg_back.sv =====
// Back end: pipelined distance divider, height divider, texture multiply
// and row clamping. Depends on rwcg_pkg for item and result types.
`default_nettype none

module rwcg_back #(
  parameter int SCREEN_ROWS = 1024
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   item_valid,
  input  wire rwcg_pkg::front_item_t  item,
  output logic                        item_pop,
  output logic                        res_valid,
  output rwcg_pkg::result_t           res,
  input  wire logic                   res_full
);

  import rwcg_pkg::*;

  localparam int DIV1_STAGES = DIST_W;
  localparam int DIV2_STAGES = HGT_W;
  localparam int RW = 17;
  localparam logic [DIST_W-1:0] ROWS_D = DIST_W'(SCREEN_ROWS);
  localparam logic [RW-1:0]     HALF_V = RW'(SCREEN_ROWS / 2);
  localparam logic [RW-1:0]     ROWS_V = RW'(SCREEN_ROWS);
  localparam logic [RW-1:0]     LAST_V = RW'(SCREEN_ROWS - 1);

  typedef struct packed {
    item_kind_t              kind;
    logic                    qovf;
    logic [AD_W-1:0]         ad;
    logic [AD_W-1:0]         rem;
    logic [DIST_W-1:0]       quo;
    logic [AN_LO_W-1:0]      an_lo;
    logic [FRAC_W-1:0]       opos;
    logic signed [DIR_W-1:0] odir;
  } div_stage_t;

  typedef struct packed {
    logic [DIST_W-1:0] perp_dist;
    logic              sat;
    logic              hovf;
    logic [DIST_W-1:0] rem;
    logic [HGT_W-1:0]  quo;
    logic [FRAC_W-1:0] opos;
    logic [FRAC_W-1:0] prod_hi;
  } hgt_stage_t;

  function automatic div_stage_t div1_step(div_stage_t cur);
    div_stage_t    nxt;
    logic [AD_W:0] trial;
    logic [AD_W:0] diff;
    nxt   = cur;
    trial = {cur.rem, cur.an_lo[AN_LO_W-1]};
    diff  = trial - {1'b0, cur.ad};
    nxt.an_lo = {cur.an_lo[AN_LO_W-2:0], 1'b0};
    if (trial >= {1'b0, cur.ad}) begin
      nxt.rem = diff[AD_W-1:0];
      nxt.quo = {cur.quo[DIST_W-2:0], 1'b1};
    end else begin
      nxt.rem = trial[AD_W-1:0];
      nxt.quo = {cur.quo[DIST_W-2:0], 1'b0};
    end
    return nxt;
  endfunction

  function automatic hgt_stage_t div2_step(hgt_stage_t cur);
    hgt_stage_t      nxt;
    logic [DIST_W:0] trial;
    logic [DIST_W:0] diff;
    nxt   = cur;
    trial = {cur.rem, 1'b0};
    diff  = trial - {1'b0, cur.perp_dist};
    if (trial >= {1'b0, cur.perp_dist}) begin
      nxt.rem = diff[DIST_W-1:0];
      nxt.quo = {cur.quo[HGT_W-2:0], 1'b1};
    end else begin
      nxt.rem = trial[DIST_W-1:0];
      nxt.quo = {cur.quo[HGT_W-2:0], 1'b0};
    end
    return nxt;
  endfunction

  div_stage_t d1 [0:DIV1_STAGES];
  logic       v1 [0:DIV1_STAGES];
  hgt_stage_t h  [0:DIV2_STAGES];
  logic       vh [0:DIV2_STAGES];

  logic                       en;
  div_stage_t                 d1_load;
  logic [DIST_W-1:0]          perp_dist;
  logic                       dist_sat;
  logic signed [DIST_W+DIR_W:0] prod;
  hgt_stage_t                 h_load;
  logic [HGT_W-1:0]           height;
  logic [RW-1:0]              hh;
  logic [RW-1:0]              row_sum;
  logic [RW-1:0]              ds;
  logic [RW-1:0]              de;

  // hold the whole pipeline while the last stage waits on a full queue
  assign en        = !(vh[DIV2_STAGES] && res_full);
  assign item_pop  = en && item_valid;
  assign res_valid = en && vh[DIV2_STAGES];

  always_comb begin
    d1_load.kind  = item.kind;
    d1_load.qovf  = item.qovf;
    d1_load.ad    = item.ad;
    d1_load.rem   = AD_W'(item.an_hi);
    d1_load.quo   = '0;
    d1_load.an_lo = item.an_lo;
    d1_load.opos  = item.opos;
    d1_load.odir  = item.odir;
  end

  always_comb begin
    case (d1[DIV1_STAGES].kind)
      KIND_NO_DIR: perp_dist = DIST_MAX;
      KIND_BEHIND: perp_dist = DIST_MIN;
      KIND_DIVIDE: perp_dist = d1[DIV1_STAGES].qovf ? DIST_MAX : d1[DIV1_STAGES].quo;
      default:     perp_dist = DIST_MAX;
    endcase
    dist_sat = (d1[DIV1_STAGES].kind == KIND_NO_DIR) || (perp_dist == '0);
    prod     = $signed({1'b0, perp_dist}) * d1[DIV1_STAGES].odir;

    h_load.perp_dist = perp_dist;
    h_load.sat       = dist_sat;
    // height reaches 2^16 whenever the distance is <= SCREEN_ROWS, zero included
    h_load.hovf      = (perp_dist <= ROWS_D);
    h_load.rem       = ROWS_D;
    h_load.quo       = '0;
    h_load.opos      = d1[DIV1_STAGES].opos;
    h_load.prod_hi   = prod[31:16];
  end

  always_comb begin
    height  = h[DIV2_STAGES].hovf ? HEIGHT_MAX : h[DIV2_STAGES].quo;
    hh      = RW'(height[HGT_W-1:1]);
    row_sum = HALF_V + hh;
    ds      = (hh > HALF_V) ? '0 : HALF_V - hh;
    de      = (row_sum >= ROWS_V) ? LAST_V : row_sum;

    res.wall_distance = h[DIV2_STAGES].perp_dist;
    res.slice_height  = height;
    res.row_first     = ds[ROW_W-1:0];
    res.row_last      = de[ROW_W-1:0];
    res.texture_frac  = h[DIV2_STAGES].opos + h[DIV2_STAGES].prod_hi;
    res.saturated     = h[DIV2_STAGES].sat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s <= DIV1_STAGES; s++) begin
        v1[s] <= 1'b0;
      end
      for (int s = 0; s <= DIV2_STAGES; s++) begin
        vh[s] <= 1'b0;
      end
    end else if (en) begin
      v1[0] <= item_valid;
      for (int s = 0; s < DIV1_STAGES; s++) begin
        v1[s+1] <= v1[s];
      end
      vh[0] <= v1[DIV1_STAGES];
      for (int s = 0; s < DIV2_STAGES; s++) begin
        vh[s+1] <= vh[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1[0] <= d1_load;
      for (int s = 0; s < DIV1_STAGES; s++) begin
        d1[s+1] <= div1_step(d1[s]);
      end
      h[0] <= h_load;
      for (int s = 0; s < DIV2_STAGES; s++) begin
        h[s+1] <= div2_step(h[s]);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/raycast_wall_column_geometry_core.sv =====
// Raycaster wall column geometry core: front end, work queue, back end.
// One item per cycle is sustained while the result queue is not full,
// through the 24-stage distance divider and the 16-stage height divider
// (one quotient bit each).
// Synchronous reset clears the valid bits and queue counts; payload
// registers are not reset and no clearing pass is needed.
`default_nettype none

module raycast_wall_column_geometry_core #(
  parameter int SCREEN_ROWS = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [23:0]        viewer_x,
  input  wire logic [23:0]        viewer_y,
  input  wire logic signed [18:0] dir_x,
  input  wire logic signed [18:0] dir_y,
  input  wire logic [7:0]         cell_x,
  input  wire logic [7:0]         cell_y,
  input  wire logic               hit_side,
  output logic                    empty,
  input  wire logic               pop,
  output logic [23:0]             wall_distance,
  output logic [15:0]             slice_height,
  output logic [9:0]              row_first,
  output logic [9:0]              row_last,
  output logic [15:0]             texture_frac,
  output logic                    saturated
);

  import rwcg_pkg::*;

  localparam int ITEM_W = $bits(front_item_t);
  localparam int RES_W  = $bits(result_t);

  logic          front_valid;
  front_item_t   front_item;
  logic          mid_full;
  logic          mid_empty;
  logic [ITEM_W-1:0] mid_dout;
  front_item_t   back_item;
  logic          back_pop;
  logic          res_valid;
  result_t       res;
  logic          res_full;
  logic [RES_W-1:0] out_dout;
  result_t       out_item;

  rwcg_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .viewer_x   (viewer_x),
    .viewer_y   (viewer_y),
    .dir_x      (dir_x),
    .dir_y      (dir_y),
    .cell_x     (cell_x),
    .cell_y     (cell_y),
    .hit_side   (hit_side),
    .item_valid (front_valid),
    .item       (front_item),
    .item_full  (mid_full)
  );

  rwcg_fifo #(
    .WIDTH (ITEM_W),
    .DEPTH (4)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (front_valid),
    .full  (mid_full),
    .din   (front_item),
    .empty (mid_empty),
    .pop   (back_pop),
    .dout  (mid_dout)
  );

  assign back_item = mid_dout;

  rwcg_back #(
    .SCREEN_ROWS (SCREEN_ROWS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (!mid_empty),
    .item       (back_item),
    .item_pop   (back_pop),
    .res_valid  (res_valid),
    .res        (res),
    .res_full   (res_full)
  );

  rwcg_fifo #(
    .WIDTH (RES_W),
    .DEPTH (2)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_valid),
    .full  (res_full),
    .din   (res),
    .empty (empty),
    .pop   (pop),
    .dout  (out_dout)
  );

  assign out_item      = out_dout;
  assign wall_distance = out_item.wall_distance;
  assign slice_height  = out_item.slice_height;
  assign row_first     = out_item.row_first;
  assign row_last      = out_item.row_last;
  assign texture_frac  = out_item.texture_frac;
  assign saturated     = out_item.saturated;

endmodule

`default_nettype wire

// ===== test/column_geometry_checker.sv =====
// Checker for the raycaster wall column geometry core: predicts the result of
// every accepted column item and compares each popped result against it.
// Depends on rwcg_pkg for the result struct and the saturation constants.
`timescale 1ns / 100ps

module column_geometry_checker #(
  parameter int SCREEN_ROWS = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic               full,
  input  logic [23:0]        viewer_x,
  input  logic [23:0]        viewer_y,
  input  logic signed [18:0] dir_x,
  input  logic signed [18:0] dir_y,
  input  logic [7:0]         cell_x,
  input  logic [7:0]         cell_y,
  input  logic               hit_side,
  input  logic               empty,
  input  logic               pop,
  input  logic [23:0]        wall_distance,
  input  logic [15:0]        slice_height,
  input  logic [9:0]         row_first,
  input  logic [9:0]         row_last,
  input  logic [15:0]        texture_frac,
  input  logic               saturated,
  output int                 mismatches,
  output int                 pending
);

  import rwcg_pkg::*;

  result_t expected_columns[$];
  int      mismatch_count = 0;

  assign mismatches = mismatch_count;

  // Perpendicular distance, projected height, slice rows and texture coordinate.
  function automatic result_t project_column(
    input logic [23:0]        vx,
    input logic [23:0]        vy,
    input logic signed [18:0] dx,
    input logic signed [18:0] dy,
    input logic [7:0]         cx,
    input logic [7:0]         cy,
    input logic               side
  );
    longint  cell_v, pos, dir, num, an, ad, quot, perp_dist, hgt, hh, row_lo, row_hi;
    longint  opos, odir, along;
    longint  dist_cap, dist_floor, hgt_cap;
    logic    sat;
    result_t r;
    dist_cap   = longint'(DIST_MAX);
    dist_floor = longint'(DIST_MIN);
    hgt_cap    = longint'(HEIGHT_MAX);
    sat        = 1'b0;
    cell_v = side ? longint'(cy) : longint'(cx);
    pos    = side ? longint'(vy) : longint'(vx);
    dir    = side ? longint'(dy) : longint'(dx);
    // A negative step lands on the far face of the cell.
    num = cell_v * 65536 - pos + ((dir < 0) ? 65536 : 0);
    if (dir == 0) begin
      perp_dist = dist_cap;
      sat       = 1'b1;
    end else if (num != 0 && ((num < 0) != (dir < 0))) begin
      // Wall behind the viewer: clamp to the small positive minimum.
      perp_dist = dist_floor;
    end else begin
      an        = (num < 0) ? -num : num;
      ad        = (dir < 0) ? -dir : dir;
      quot      = (an << 16) / ad;
      perp_dist = (quot > dist_cap) ? dist_cap : quot;
    end
    if (perp_dist == 0) begin
      hgt = hgt_cap;
      sat = 1'b1;
    end else begin
      hgt = (longint'(SCREEN_ROWS) << 16) / perp_dist;
      if (hgt > hgt_cap) hgt = hgt_cap;
    end
    hh     = hgt / 2;
    row_lo = SCREEN_ROWS / 2 - hh;
    row_hi = SCREEN_ROWS / 2 + hh;
    if (row_lo < 0) row_lo = 0;
    if (row_hi >= SCREEN_ROWS) row_hi = SCREEN_ROWS - 1;
    opos  = side ? longint'(vx) : longint'(vy);
    odir  = side ? longint'(dx) : longint'(dy);
    along = (opos << 16) + perp_dist * odir;
    r.wall_distance = perp_dist[23:0];
    r.slice_height  = hgt[15:0];
    r.row_first     = row_lo[9:0];
    r.row_last      = row_hi[9:0];
    r.texture_frac  = along[31:16];
    r.saturated     = sat;
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] column check: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [23:0] want, input logic [23:0] seen);
    if (seen !== want)
      report_mismatch($sformatf("%s expected %0d got %0d", name, want, seen));
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      if (pop && !empty) begin
        if (expected_columns.size() == 0) begin
          report_mismatch("result popped with no item outstanding");
        end else begin
          want = expected_columns.pop_front();
          check_field("wall_distance", want.wall_distance, wall_distance);
          check_field("slice_height", want.slice_height, slice_height);
          check_field("row_first", want.row_first, row_first);
          check_field("row_last", want.row_last, row_last);
          check_field("texture_frac", want.texture_frac, texture_frac);
          check_field("saturated", want.saturated, saturated);
        end
      end
      if (push && !full)
        expected_columns.push_back(project_column(viewer_x, viewer_y, dir_x, dir_y,
                                                  cell_x, cell_y, hit_side));
      pending <= expected_columns.size();
    end
  end

endmodule

// ===== test/tb_top.sv =====
// Top of the wall column geometry testbench: clock, reset, column stimulus
// and result popping with random idling, and the final verdict.
// Depends on rwcg_pkg, the core and column_geometry_checker.
`timescale 1ns / 100ps

module tb_top;
  import rwcg_pkg::*;

  localparam int ROWS         = 1024;
  localparam int COLUMN_COUNT = 1250;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 60;
  localparam int DIR_TOP      = 262143;
  localparam int DIR_BOTTOM   = -262144;
  localparam int POS_TOP      = 24'hFF_FFFF;

  typedef struct {
    logic [23:0]        vx;
    logic [23:0]        vy;
    logic signed [18:0] dx;
    logic signed [18:0] dy;
    logic [7:0]         cx;
    logic [7:0]         cy;
    logic               side;
  } column_t;

  logic               clk      = 1'b0;
  logic               rst      = 1'b1;
  logic               push     = 1'b0;
  logic               pop      = 1'b0;
  logic [23:0]        viewer_x = '0;
  logic [23:0]        viewer_y = '0;
  logic signed [18:0] dir_x    = '0;
  logic signed [18:0] dir_y    = '0;
  logic [7:0]         cell_x   = '0;
  logic [7:0]         cell_y   = '0;
  logic               hit_side = 1'b0;
  logic               full;
  logic               empty;
  logic [23:0]        wall_distance;
  logic [15:0]        slice_height;
  logic [9:0]         row_first;
  logic [9:0]         row_last;
  logic [15:0]        texture_frac;
  logic               saturated;
  int                 errors;
  int                 pending;
  int                 cycles     = 0;
  bit                 send_burst = 1'b0;
  bit                 take_burst = 1'b0;

  always #10 clk = ~clk;

  raycast_wall_column_geometry_core #(.SCREEN_ROWS(ROWS)) dut (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .viewer_x(viewer_x), .viewer_y(viewer_y), .dir_x(dir_x), .dir_y(dir_y),
    .cell_x(cell_x), .cell_y(cell_y), .hit_side(hit_side),
    .empty(empty), .pop(pop),
    .wall_distance(wall_distance), .slice_height(slice_height),
    .row_first(row_first), .row_last(row_last),
    .texture_frac(texture_frac), .saturated(saturated)
  );

  column_geometry_checker #(.SCREEN_ROWS(ROWS)) column_check (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .viewer_x(viewer_x), .viewer_y(viewer_y), .dir_x(dir_x), .dir_y(dir_y),
    .cell_x(cell_x), .cell_y(cell_y), .hit_side(hit_side),
    .empty(empty), .pop(pop),
    .wall_distance(wall_distance), .slice_height(slice_height),
    .row_first(row_first), .row_last(row_last),
    .texture_frac(texture_frac), .saturated(saturated),
    .mismatches(errors), .pending(pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic column_t make_column(int vx, int vy, int dx, int dy,
                                          int cx, int cy, bit side);
    column_t c;
    c.vx   = vx[23:0];
    c.vy   = vy[23:0];
    c.dx   = dx[18:0];
    c.dy   = dy[18:0];
    c.cx   = cx[7:0];
    c.cy   = cy[7:0];
    c.side = side;
    return c;
  endfunction

  // Mostly rays that really reach the cell, then edge cases and raw noise.
  function automatic column_t random_column();
    int      hpos, hdir, hcell, opos, odir, ocell, mag, k, pick;
    bit      neg, side;
    column_t c;
    side = $urandom_range(0, 1);
    neg  = $urandom_range(0, 1);
    hpos = $urandom_range(0, POS_TOP);
    case ($urandom_range(0, 3))
      0:       mag = $urandom_range(1, 255);
      1:       mag = $urandom_range(256, 65536);
      default: mag = $urandom_range(1, neg ? 262144 : DIR_TOP);
    endcase
    hdir  = neg ? -mag : mag;
    k     = $urandom_range(0, 6);
    hcell = (hpos >> 16) + (neg ? -k : k);
    if (hcell < 0) hcell = 0;
    if (hcell > 255) hcell = 255;
    opos  = $urandom_range(0, POS_TOP);
    odir  = $urandom_range(0, 524287) + DIR_BOTTOM;
    ocell = $urandom_range(0, 255);
    pick  = $urandom_range(0, 99);
    if (pick >= 60 && pick < 80) begin
      case ($urandom_range(0, 2))
        0: begin
          case ($urandom_range(0, 4))
            0:       hdir = 0;
            1:       hdir = 1;
            2:       hdir = -1;
            3:       hdir = DIR_TOP;
            default: hdir = DIR_BOTTOM;
          endcase
        end
        1: begin
          // Put the viewer exactly on the face that the ray hits.
          if (hdir < 0 && hcell < 255) hpos = (hcell + 1) << 16;
          else hpos = hcell << 16;
        end
        default: hcell = $urandom_range(0, 255);
      endcase
    end
    if (side)
      c = make_column(opos, hpos, odir, hdir, ocell, hcell, side);
    else
      c = make_column(hpos, opos, hdir, odir, hcell, ocell, side);
    if (pick >= 80) begin
      c.vx   = 24'($urandom());
      c.vy   = 24'($urandom());
      c.dx   = 19'($urandom());
      c.dy   = 19'($urandom());
      c.cx   = 8'($urandom());
      c.cy   = 8'($urandom());
      c.side = 1'($urandom());
    end
    return c;
  endfunction

  task automatic send_column(input column_t c);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push     <= 1'b1;
    viewer_x <= c.vx;
    viewer_y <= c.vy;
    dir_x    <= c.dx;
    dir_y    <= c.dy;
    cell_x   <= c.cx;
    cell_y   <= c.cy;
    hit_side <= c.side;
    do @(posedge clk); while (full);
  endtask

  // Result side: pop with random stalls, sometimes in long unstalled runs.
  initial begin
    int stall, taken;
    taken = 0;
    do @(posedge clk); while (rst);
    forever begin
      if (taken % 100 == 0) take_burst = ($urandom_range(0, 3) == 0);
      stall = take_burst ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      taken++;
    end
  end

  initial begin
    int n;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Ordinary hits on both faces, then the tall slice and a half-screen one.
    send_column(make_column(32'h02_8000, 32'h03_0000, 65536, 32768, 5, 9, 1'b0));
    send_column(make_column(32'h02_8000, 32'h03_0000, 32768, 65536, 5, 9, 1'b1));
    send_column(make_column(2 << 16, 7 << 16, 65536, -20000, 3, 0, 1'b0));
    send_column(make_column(7 << 16, 2 << 16, -20000, 65536, 0, 4, 1'b1));
    // Zero direction on the hit axis.
    send_column(make_column(32'h05_1234, 32'h06_0000, 0, 40000, 8, 8, 1'b0));
    send_column(make_column(32'h05_1234, 32'h06_0000, 40000, 0, 8, 8, 1'b1));
    // Wall behind the viewer in both step directions.
    send_column(make_column(5 << 16, 5 << 16, 65536, 12345, 1, 0, 1'b0));
    send_column(make_column(5 << 16, 2 << 16, -12345, -65536, 0, 9, 1'b1));
    // Distance overflow with the smallest direction, then a wall behind.
    send_column(make_column(0, 0, 1, -1, 255, 0, 1'b0));
    send_column(make_column(0, 0, -1, -1, 0, 0, 1'b0));
    // Zero distance from either side of the face.
    send_column(make_column(10 << 16, 0, 16384, 100, 10, 0, 1'b0));
    send_column(make_column(0, 11 << 16, 100, -16384, 0, 10, 1'b1));
    // Tiny distance: height overflow.
    send_column(make_column((3 << 16) - 5, 0, 65536, DIR_BOTTOM, 3, 0, 1'b0));
    // Field extremes.
    send_column(make_column(POS_TOP, POS_TOP, DIR_BOTTOM, DIR_BOTTOM, 255, 255, 1'b0));
    send_column(make_column(POS_TOP, POS_TOP, DIR_BOTTOM, DIR_BOTTOM, 255, 255, 1'b1));
    send_column(make_column(0, 0, DIR_TOP, DIR_TOP, 0, 0, 1'b0));
    send_column(make_column(0, 0, DIR_TOP, DIR_TOP, 0, 0, 1'b1));
    send_column(make_column(0, POS_TOP, DIR_TOP, DIR_BOTTOM, 255, 0, 1'b0));
    send_column(make_column(POS_TOP, 0, DIR_BOTTOM, DIR_TOP, 0, 255, 1'b1));
    // Large distance times a steep other component: texture wraps.
    send_column(make_column(0, 32'h80_0000, 3, DIR_BOTTOM, 200, 7, 1'b0));

    for (n = 0; n < COLUMN_COUNT; n++) begin
      if (n % 100 == 0) send_burst = ($urandom_range(0, 3) == 0);
      send_column(random_column());
    end
    push <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
